[design/aesctr_pkg.sv]
// Shared types, constants and AES helper functions for the AES-128 CTR stream unit.
package aesctr_pkg;

    localparam int unsigned BLOCK_W  = 128;
    localparam int unsigned NUM_RK   = 11;
    localparam logic [3:0]  LAST_RND = 4'd10;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_UPPER = 2'd0;
    localparam logic [1:0] REG_KEY_LOWER = 2'd1;
    localparam logic [1:0] REG_CTR_UPPER = 2'd2;
    localparam logic [1:0] REG_CTR_LOWER = 2'd3;

    // One classified item handed from the front end to the engine.
    typedef struct packed {
        logic [7:0] data;
        logic       eom;
        logic       start;
        logic [3:0] pos;
    } item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPAND,
        S_ENC,
        S_EMIT
    } eng_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by two in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte j of a block, byte 0 in the top bits.
    function automatic logic [7:0] blk_byte(input logic [127:0] s, input int j);
        return s[127-8*j -: 8];
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic last);
        logic [7:0] x [16];
        logic [7:0] y [16];
        logic [7:0] a, b, c, d, e;
        logic [127:0] r;
        for (int j = 0; j < 16; j++) begin
            x[j] = SBOX[blk_byte(s, j)];
        end
        for (int col = 0; col < 4; col++) begin
            for (int row = 0; row < 4; row++) begin
                y[row + 4*col] = x[row + 4*((col + row) % 4)];
            end
        end
        if (!last) begin
            for (int col = 0; col < 4; col++) begin
                a = y[4*col];
                b = y[4*col+1];
                c = y[4*col+2];
                d = y[4*col+3];
                e = a ^ b ^ c ^ d;
                y[4*col]   = a ^ e ^ xtime(a ^ b);
                y[4*col+1] = b ^ e ^ xtime(b ^ c);
                y[4*col+2] = c ^ e ^ xtime(c ^ d);
                y[4*col+3] = d ^ e ^ xtime(d ^ a);
            end
        end
        for (int j = 0; j < 16; j++) begin
            r[127-8*j -: 8] = y[j];
        end
        return r ^ rk;
    endfunction

    // Next round key from the previous one and the round constant.
    function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t, n0, n1, n2, n3;
        t  = {SBOX[blk_byte(k, 13)] ^ rc, SBOX[blk_byte(k, 14)],
              SBOX[blk_byte(k, 15)], SBOX[blk_byte(k, 12)]};
        n0 = k[127:96] ^ t;
        n1 = k[95:64] ^ n0;
        n2 = k[63:32] ^ n1;
        n3 = k[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

[design/aesctr_front.sv]
// Front end: accepts bytes, tags message start and block position, queues them.
module aesctr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // data_byte
    input  logic                 s_tlast,   // end_of_message
    output logic                 item_valid,
    output aesctr_pkg::item_t    item,
    input  logic                 item_pop
);

    aesctr_pkg::item_t q_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              in_msg_reg, in_msg_next;
    logic [3:0]        pos_reg, pos_next;
    logic              push;
    aesctr_pkg::item_t new_item;

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    // Classify the incoming item against the message state.
    always_comb
    begin
        new_item.data  = s_tdata;
        new_item.eom   = s_tlast;
        new_item.start = !in_msg_reg;
        new_item.pos   = in_msg_reg ? pos_reg : 4'd0;
        in_msg_next    = in_msg_reg;
        pos_next       = pos_reg;
        if (push)
        begin
            in_msg_next = !s_tlast;
            pos_next    = new_item.pos + 4'd1;
        end
    end

    // Queue pointers and occupancy.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            in_msg_reg <= 1'b0;
            pos_reg    <= 4'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            in_msg_reg <= in_msg_next;
            pos_reg    <= pos_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> count_reg != 2'd0)
        else $error("item popped from an empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue occupancy out of range");
    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !in_msg_reg) |=> pos_reg == 4'd1)
        else $error("block position not restarted at message start");
`endif

endmodule

[design/aesctr_back.sv]
// Back end: key expansion per message, counter encryption per block and keystream XOR for each item.
module aesctr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  aesctr_pkg::item_t    item,
    output logic                 item_pop,
    input  logic [127:0]         key,
    input  logic [127:0]         ctr_init,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // result_byte
    output logic                 m_tlast    // last_byte
);

    aesctr_pkg::eng_state_t state_reg, state_next;
    aesctr_pkg::item_t      cur_reg;
    logic [127:0]           rk_reg [aesctr_pkg::NUM_RK];
    logic [127:0]           ctr_reg;
    logic [127:0]           x_reg;
    logic [7:0]             rc_reg;
    logic [3:0]             rnd_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_data_reg;
    logic                   out_last_reg;
    logic                   out_free;
    logic                   load_out;
    logic                   enc_setup;
    logic                   last_step;

    assign out_free  = !out_valid_reg || m_tready;
    assign last_step = (rnd_reg == aesctr_pkg::LAST_RND);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aesctr_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.start)
                        state_next = aesctr_pkg::S_EXPAND;
                    else if (item.pos == 4'd0)
                        state_next = aesctr_pkg::S_ENC;
                    else
                        state_next = aesctr_pkg::S_EMIT;
                end
            end
            aesctr_pkg::S_EXPAND:
            begin
                if (rnd_reg == aesctr_pkg::LAST_RND - 4'd1)
                    state_next = aesctr_pkg::S_ENC;
            end
            aesctr_pkg::S_ENC:
            begin
                if (last_step)
                    state_next = aesctr_pkg::S_EMIT;
            end
            aesctr_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = aesctr_pkg::S_IDLE;
            end
            default: state_next = aesctr_pkg::S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        item_pop  = 1'b0;
        load_out  = 1'b0;
        enc_setup = 1'b0;
        unique case (state_reg)
            aesctr_pkg::S_IDLE:
            begin
                item_pop  = item_valid;
                enc_setup = item_valid && !item.start && (item.pos == 4'd0);
            end
            aesctr_pkg::S_EXPAND: enc_setup = (rnd_reg == aesctr_pkg::LAST_RND - 4'd1);
            aesctr_pkg::S_ENC:    ;
            aesctr_pkg::S_EMIT:   load_out = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aesctr_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            rnd_reg       <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (item_pop || enc_setup)
                rnd_reg <= enc_setup ? 4'd1 : 4'd0;
            else if (state_reg == aesctr_pkg::S_EXPAND || state_reg == aesctr_pkg::S_ENC)
                rnd_reg <= rnd_reg + 4'd1;
        end
    end

    // Datapath: round keys, counter, cipher state and output item.
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            cur_reg <= item;
            if (item.start)
            begin
                rk_reg[0] <= key;
                ctr_reg   <= ctr_init;
                rc_reg    <= 8'h01;
            end
        end
        if (state_reg == aesctr_pkg::S_EXPAND && !enc_setup)
        begin
            rk_reg[rnd_reg + 4'd1] <= aesctr_pkg::key_next(rk_reg[rnd_reg], rc_reg);
            rc_reg                 <= aesctr_pkg::xtime(rc_reg);
        end
        if (state_reg == aesctr_pkg::S_EXPAND && enc_setup)
        begin
            rk_reg[rnd_reg + 4'd1] <= aesctr_pkg::key_next(rk_reg[rnd_reg], rc_reg);
        end
        if (enc_setup)
        begin
            x_reg <= (item_pop ? ctr_reg : ctr_reg) ^ rk_reg[0];
        end
        if (state_reg == aesctr_pkg::S_ENC)
        begin
            x_reg <= aesctr_pkg::aes_round(x_reg, rk_reg[rnd_reg], last_step);
            if (last_step)
                ctr_reg <= ctr_reg + 128'd1;
        end
        if (load_out)
        begin
            out_data_reg <= cur_reg.data ^ x_reg[127 - 8*cur_reg.pos -: 8];
            out_last_reg <= cur_reg.eom;
        end
    end

`ifndef NO_ASSERTIONS
    a_expand_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == aesctr_pkg::S_EXPAND |-> cur_reg.start)
        else $error("key expansion for an item that does not open a message");
    a_enc_at_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == aesctr_pkg::S_ENC |-> cur_reg.pos == 4'd0)
        else $error("encryption outside a block boundary");
    a_enc_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == aesctr_pkg::S_ENC |-> (rnd_reg != 4'd0 && rnd_reg <= aesctr_pkg::LAST_RND))
        else $error("round counter out of range");
    a_emit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result item lost on load");
`endif

endmodule

[design/aes128_ctr_stream_cipher_unit.sv]
// Top level of the AES-128 CTR stream unit: configuration registers, front end and engine.
// The engine handles one byte at a time and pops the next only once the result of the last
// is in the output register. A byte that opens a 16-byte block first waits for the counter
// to be encrypted, and the first byte of a message also waits for the key expansion.
// Reset (rst_n, asynchronous, active low) clears registers, queue and message state.
module aes128_ctr_stream_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic        s_tlast,    // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // result_byte
    output logic        m_tlast,    // last_byte
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]       key_upper_reg, key_lower_reg;
    logic [63:0]       ctr_upper_reg, ctr_lower_reg;
    logic              item_valid;
    logic              item_pop;
    aesctr_pkg::item_t item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= 64'd0;
            key_lower_reg <= 64'd0;
            ctr_upper_reg <= 64'd0;
            ctr_lower_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aesctr_pkg::REG_KEY_UPPER: key_upper_reg <= cfg_data;
                aesctr_pkg::REG_KEY_LOWER: key_lower_reg <= cfg_data;
                aesctr_pkg::REG_CTR_UPPER: ctr_upper_reg <= cfg_data;
                aesctr_pkg::REG_CTR_LOWER: ctr_lower_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    aesctr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    aesctr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .key        ({key_upper_reg, key_lower_reg}),
        .ctr_init   ({ctr_upper_reg, ctr_lower_reg}),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

[tb/aes128_ctr_stream_cipher_unit_tb.sv]
// Self-checking testbench for the AES-128 CTR byte-stream unit.
module aes128_ctr_stream_cipher_unit_tb;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } cipher_byte_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        logic [7:0] pinned_val;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic        s_tlast;    // end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // result_byte
    logic        m_tlast;    // last_byte
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    // Predictor state: registers, message state, counter, keystream and round keys.
    logic [63:0]  key_hi, key_lo, ctr_init_hi, ctr_init_lo;
    logic         msg_open;
    logic [127:0] ctr_block;
    logic [7:0]   ks_bytes [16];
    logic [3:0]   ks_pos;
    logic [127:0] round_keys [11];
    logic [7:0]   sub_table [256];

    cipher_byte_t expected_q[$];
    int           error_count;
    bit           idling;
    bit           hold_ask;
    int           rx_wait;
    bit           pin_valid;
    logic [7:0]   pin_value;

    // Directed table: zero key and zero counter after reset give the known
    // keystream 66 e9 4b d4 ..., so the first bytes are pinned by hand.
    stim_row_t directed [20] = '{
        '{8'h00, 1'b0, 1'b1, 8'h66},
        '{8'hff, 1'b0, 1'b1, 8'h16},
        '{8'h00, 1'b0, 1'b1, 8'h4b},
        '{8'hff, 1'b0, 1'b1, 8'h2b},
        '{8'h01, 1'b0, 1'b0, 8'h00},
        '{8'h80, 1'b0, 1'b0, 8'h00},
        '{8'h55, 1'b0, 1'b0, 8'h00},
        '{8'haa, 1'b0, 1'b0, 8'h00},
        '{8'h0f, 1'b0, 1'b0, 8'h00},
        '{8'hf0, 1'b0, 1'b0, 8'h00},
        '{8'h11, 1'b0, 1'b0, 8'h00},
        '{8'h22, 1'b0, 1'b0, 8'h00},
        '{8'h33, 1'b0, 1'b0, 8'h00},
        '{8'h44, 1'b0, 1'b0, 8'h00},
        '{8'h66, 1'b0, 1'b0, 8'h00},
        '{8'h77, 1'b0, 1'b0, 8'h00},
        '{8'h99, 1'b0, 1'b0, 8'h00},
        '{8'hff, 1'b1, 1'b0, 8'h00},
        '{8'h80, 1'b1, 1'b1, 8'he6},
        '{8'h00, 1'b1, 1'b1, 8'h66}
    };

    aes128_ctr_stream_cipher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Multiplication in GF(2^8) with the AES polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    // Builds the substitution table from the field inverse and the affine map.
    function automatic void build_sub_table();
        logic [7:0] inv, s;
        for (int i = 0; i < 256; i++)
        begin
            inv = 8'h01;
            if (i == 0)
                inv = 8'h00;
            else
                for (int k = 0; k < 254; k++)
                    inv = gf_mul(inv, 8'(i));
            s = inv ^ 8'h63;
            for (int n = 1; n < 5; n++)
                s = s ^ 8'((inv << n) | (inv >> (8 - n)));
            sub_table[i] = s;
        end
    endfunction

    // Expands the configured key into the eleven round keys.
    function automatic void expand_round_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0]  rcon;
        rcon = 8'h01;
        {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
        for (int i = 4; i < 44; i++)
        begin
            t = w[i-1];
            if (i % 4 == 0)
            begin
                t = {sub_table[t[23:16]] ^ rcon, sub_table[t[15:8]],
                     sub_table[t[7:0]], sub_table[t[31:24]]};
                rcon = gf_mul(rcon, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < 11; r++)
            round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    // Encrypts the counter block into the keystream, then steps the counter.
    function automatic void encrypt_counter_block();
        logic [127:0] st;
        logic [7:0]   x [16];
        logic [7:0]   y [16];
        st = ctr_block ^ round_keys[0];
        for (int r = 1; r <= 10; r++)
        begin
            for (int j = 0; j < 16; j++)
                x[j] = sub_table[st[127-8*j -: 8]];
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    y[row + 4*c] = x[row + 4*((c + row) % 4)];
            if (r < 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    for (int row = 0; row < 4; row++)
                        x[4*c + row] = gf_mul(y[4*c + row], 8'h02)
                                     ^ gf_mul(y[4*c + (row + 1) % 4], 8'h03)
                                     ^ y[4*c + (row + 2) % 4] ^ y[4*c + (row + 3) % 4];
                end
                y = x;
            end
            for (int j = 0; j < 16; j++)
                st[127-8*j -: 8] = y[j];
            st = st ^ round_keys[r];
        end
        for (int j = 0; j < 16; j++)
            ks_bytes[j] = st[127-8*j -: 8];
        ctr_block = ctr_block + 128'd1;
    endfunction

    // Works out the output byte for one accepted input byte.
    function automatic cipher_byte_t cipher_next(input logic [7:0] d, input logic last);
        cipher_byte_t res;
        if (!msg_open)
        begin
            expand_round_keys();
            ctr_block = {ctr_init_hi, ctr_init_lo};
            ks_pos = 4'd0;
            msg_open = 1'b1;
        end
        if (ks_pos == 4'd0)
            encrypt_counter_block();
        res.data = d ^ ks_bytes[ks_pos];
        res.last = last;
        ks_pos = ks_pos + 4'd1;
        if (last)
            msg_open = 1'b0;
        return res;
    endfunction

    // Input side: every accepted item is predicted at the edge that takes it.
    always @(posedge clk)
    begin
        cipher_byte_t res;
        if (rst_n && s_tvalid && s_tready)
        begin
            res = cipher_next(s_tdata, s_tlast);
            if (pin_valid)
                res.data = pin_value;
            expected_q.push_back(res);
        end
    end

    // Output side: compare each accepted item with the oldest expectation.
    always @(posedge clk)
    begin
        cipher_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected output item: expected none, actual %02h/%0b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata !== want.data)
                begin
                    $display("%0t: result_byte mismatch: expected %02h, actual %02h",
                             $time, want.data, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_ask)
        begin
            hold_ask = 1'b0;
            rx_wait <= 300;
            m_tready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            m_tready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            rx_wait <= $urandom_range(0, 14);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Writes one configuration register and mirrors it in the predictor.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            aesctr_pkg::REG_KEY_UPPER: key_hi = val;
            aesctr_pkg::REG_KEY_LOWER: key_lo = val;
            aesctr_pkg::REG_CTR_UPPER: ctr_init_hi = val;
            aesctr_pkg::REG_CTR_LOWER: ctr_init_lo = val;
        endcase
    endtask

    // Offers one item, possibly after a random gap, and waits for it to be taken.
    task automatic send_byte(input logic [7:0] d, input logic last);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Lets all outstanding items drain so that registers may be rewritten.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Sends random messages, mostly short, until n bytes have gone in.
    // The last message may be left open when leave_open is set.
    task automatic random_messages(input int n, input bit leave_open);
        int left, len;
        left = n;
        while (left > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
            if (len > left)
                len = left;
            left -= len;
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom), (i == len - 1) && !(leave_open && left == 0));
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [63:0] r0, r1;
        error_count = 0;
        idling = 1'b1;
        hold_ask = 1'b0;
        rx_wait = 0;
        pin_valid = 1'b0;
        pin_value = 8'h00;
        key_hi = '0;
        key_lo = '0;
        ctr_init_hi = '0;
        ctr_init_lo = '0;
        msg_open = 1'b0;
        ctr_block = '0;
        ks_pos = 4'd0;
        for (int j = 0; j < 16; j++)
            ks_bytes[j] = 8'h00;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = aesctr_pkg::REG_KEY_UPPER;
        cfg_data = '0;
        build_sub_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset configuration; the pin travels with its item.
        foreach (directed[i])
        begin
            pin_valid <= directed[i].pinned;
            pin_value <= directed[i].pinned_val;
            send_byte(directed[i].data, directed[i].last);
        end
        pin_valid <= 1'b0;
        drain();

        // All-ones key and counter: the counter wraps to zero after one block.
        write_reg(aesctr_pkg::REG_KEY_UPPER, '1);
        write_reg(aesctr_pkg::REG_KEY_LOWER, '1);
        write_reg(aesctr_pkg::REG_CTR_UPPER, '1);
        write_reg(aesctr_pkg::REG_CTR_LOWER, '1);
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom), i == 39);
        drain();

        // Standard key, carry from the low half into the high half.
        write_reg(aesctr_pkg::REG_KEY_UPPER, 64'h2b7e151628aed2a6);
        write_reg(aesctr_pkg::REG_KEY_LOWER, 64'habf7158809cf4f3c);
        write_reg(aesctr_pkg::REG_CTR_UPPER, 64'hf0f1f2f3f4f5f6f7);
        write_reg(aesctr_pkg::REG_CTR_LOWER, 64'hffffffffffffffff);
        random_messages(100, 1'b1);
        drain();

        // Registers changed in mid-message take effect only at the next message.
        write_reg(aesctr_pkg::REG_KEY_UPPER, 64'h0);
        write_reg(aesctr_pkg::REG_CTR_LOWER, 64'h0);
        hold_ask = 1'b1;
        random_messages(120, 1'b0);
        drain();

        // Random settings; the final part runs without any idling.
        for (int p = 0; p < 3; p++)
        begin
            r0 = {$urandom, $urandom};
            r1 = {$urandom, $urandom};
            write_reg(aesctr_pkg::REG_KEY_UPPER, r0);
            write_reg(aesctr_pkg::REG_KEY_LOWER, r1);
            write_reg(aesctr_pkg::REG_CTR_UPPER, {$urandom, $urandom});
            write_reg(aesctr_pkg::REG_CTR_LOWER,
                      {32'hffffffff, 32'($urandom_range(32'hfffffff0, 32'hffffffff))});
            if (p == 2)
                idling = 1'b0;
            random_messages(80, 1'b0);
            drain();
        end

        if (error_count == 0)
            $display("aes128_ctr_stream_cipher_unit_tb: clean");
        else
            $display("aes128_ctr_stream_cipher_unit_tb: errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("aes128_ctr_stream_cipher_unit_tb: errors");
        $finish;
    end

endmodule

[filelist.f]
design/aesctr_pkg.sv
design/aesctr_front.sv
design/aesctr_back.sv
design/aes128_ctr_stream_cipher_unit.sv
tb/aes128_ctr_stream_cipher_unit_tb.sv
